// ===== rtl/lfra_pkg.sv =====
// Shared types and codes for the lowest-free-room allocator.
package lfra_pkg;

	localparam int GUEST_W = 10;
	localparam int ROOM_W  = 7;
	localparam int STAT_W  = 2;

	localparam logic KIND_ARRIVE = 1'b0;
	localparam logic KIND_DEPART = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOROOM = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOHOLD = 2'd2;

	typedef struct packed {
		logic               kind;
		logic [GUEST_W-1:0] guest;
	} event_t;

	typedef struct packed {
		logic [ROOM_W-1:0] room;
		logic [ROOM_W-1:0] occupancy;
		logic [ROOM_W-1:0] peak;
		logic [STAT_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic              found;
		logic [ROOM_W-1:0] room;
	} free_room_t;

endpackage

// ===== rtl/lfra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lfra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// A read at the same address as a write returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/lfra_prio.sv =====
// Priority encoder that finds the lowest free room in the busy map.
module lfra_prio import lfra_pkg::*; #(
	parameter int ROOMS = 64
) (
	input  logic [ROOMS-1:0] busy,
	output free_room_t       free
);

	logic [ROOMS-1:0] free_map;
	logic [ROOMS-1:0] lowest;
	logic [ROOM_W-1:0] room_num;

	// Two's complement trick isolates the lowest set bit of the free map.
	assign free_map = ~busy;
	assign lowest   = free_map & (~free_map + ROOMS'(1));

	always_comb begin
		room_num = '0;
		for (int r = 0; r < ROOMS; r++) begin
			if (lowest[r]) begin
				room_num = room_num | ROOM_W'(r + 1);
			end
		end
	end

	assign free.found = |free_map;
	assign free.room  = room_num;

endmodule

// ===== rtl/lowest_free_room_allocator_unit.sv =====
// Top level of the lowest-free-room allocator.
// Each arrival or departure event gives one result; the unit sustains one event per
// clock while the output is not stalled; each event passes stage one, then the output
// register. The rate is set by the guest table, a RAM with one write and one
// registered read port: each event reads its guest's entry as it is taken and writes
// it back as it leaves stage one, with the last write forwarded to the following
// event. After reset the table is cleared one entry a cycle, with event_ready low
// until it is done. The lowest free room comes from a combinational priority encode
// over the ROOMS-bit busy map. Guest indices at or above GUESTS wrap modulo GUESTS.
module lowest_free_room_allocator_unit import lfra_pkg::*; #(
	parameter int ROOMS  = 64,
	parameter int GUESTS = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    event_valid,
	output logic    event_ready,
	input  event_t  event_data,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result_data
);

	localparam int GW = (GUESTS > 1) ? $clog2(GUESTS) : 1;

	// Guest index reduction
	logic [GUEST_W-1:0] guest_red;
	logic [GW-1:0]      rd_addr;

	always_comb begin
		guest_red = event_data.guest;
		for (int k = GUEST_W - 1; k >= 0; k--) begin
			if ((GUESTS << k) < (1 << GUEST_W)) begin
				if (32'(guest_red) >= 32'(GUESTS << k)) begin
					guest_red = guest_red - GUEST_W'(GUESTS << k);
				end
			end
		end
	end

	assign rd_addr = GW'(guest_red);

	// Control and state
	logic              valid_s1;
	logic              kind_s1;
	logic [GW-1:0]     addr_s1;
	logic [ROOMS-1:0]  busy_q;
	logic [ROOM_W-1:0] in_use_q;
	logic [ROOM_W-1:0] max_q;
	logic              fwd_valid_q;
	logic [GW-1:0]     fwd_addr_q;
	logic [ROOM_W-1:0] fwd_data_q;
	logic              clr_busy_q;
	logic [GW-1:0]     clr_addr_q;
	logic              res_valid_q;
	result_t           res_q;

	logic              accept;
	logic              s1_go;
	logic [ROOM_W-1:0] rd_data;
	logic [ROOM_W-1:0] held;
	logic [ROOM_W-1:0] new_held;
	logic [ROOMS-1:0]  busy_d;
	logic [ROOM_W-1:0] in_use_d;
	logic [ROOM_W-1:0] max_d;
	result_t           res;
	free_room_t        free;
	logic              wr_en;
	logic [GW-1:0]     wr_addr;
	logic [ROOM_W-1:0] wr_data;

	assign s1_go       = valid_s1 && (!res_valid_q || result_ready);
	assign event_ready = !clr_busy_q && (!valid_s1 || s1_go);
	assign accept      = event_valid && event_ready;

	lfra_prio #(
		.ROOMS (ROOMS)
	) u_prio (
		.busy (busy_q),
		.free (free)
	);

	assign wr_en   = clr_busy_q || s1_go;
	assign wr_addr = clr_busy_q ? clr_addr_q : addr_s1;
	assign wr_data = clr_busy_q ? '0 : new_held;

	lfra_ram #(
		.WIDTH (ROOM_W),
		.DEPTH (GUESTS)
	) u_guest_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The RAM returns the contents from before the write made at the same edge,
	// so the most recent write is held aside and takes precedence on a match.
	assign held = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data;

	always_comb begin
		busy_d        = busy_q;
		in_use_d      = in_use_q;
		max_d         = max_q;
		new_held      = held;
		res.room      = '0;
		res.status    = ST_OK;
		if (kind_s1 == KIND_ARRIVE) begin
			if (held != '0) begin
				res.room = held;
			end else if (!free.found) begin
				res.status = ST_NOROOM;
			end else begin
				res.room = free.room;
				new_held = free.room;
				for (int r = 0; r < ROOMS; r++) begin
					if (free.room == ROOM_W'(r + 1)) begin
						busy_d[r] = 1'b1;
					end
				end
				in_use_d = in_use_q + ROOM_W'(1);
				if (in_use_d > max_q) begin
					max_d = in_use_d;
				end
			end
		end else begin
			if (held == '0 || held > ROOM_W'(ROOMS)) begin
				res.status = ST_NOHOLD;
			end else begin
				res.room = held;
				new_held = '0;
				for (int r = 0; r < ROOMS; r++) begin
					if (held == ROOM_W'(r + 1)) begin
						busy_d[r] = 1'b0;
					end
				end
				if (in_use_q != '0) begin
					in_use_d = in_use_q - ROOM_W'(1);
				end
			end
		end
		res.occupancy = in_use_d;
		res.peak      = max_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			busy_q      <= '0;
			in_use_q    <= '0;
			max_q       <= '0;
			fwd_valid_q <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				busy_q      <= busy_d;
				in_use_q    <= in_use_d;
				max_q       <= max_d;
				fwd_valid_q <= 1'b1;
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (clr_busy_q) begin
				if (clr_addr_q == GW'(GUESTS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + GW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= event_data.kind;
			addr_s1 <= rd_addr;
		end
		if (s1_go) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_held;
			res_q      <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	// Occupancy must always match the number of busy rooms.
	a_occ_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(busy_q) == 32'(in_use_q))
		else $error("occupancy count disagrees with busy map");

	a_peak_bounds_occ: assert property (@(posedge clk) disable iff (!arst_n)
		max_q >= in_use_q)
		else $error("peak below current occupancy");

	// An arrival may only be refused when every room is in use.
	a_noroom_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && res.status == ST_NOROOM) |-> (&busy_q))
		else $error("arrival refused while a room was free");

	// No event is taken while the guest table is still being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |=> !valid_s1 || !$past(clr_busy_q))
		else $error("event transfer during guest table clearing");

endmodule
